/* rtl/core/horc_pkg.sv */
`timescale 1ns / 1ps
package horc_pkg;

    localparam int DEF_NUM_COMPONENTS = 42;
    localparam int DEF_NUM_SLICES     = 7;
    localparam int DEF_NUM_RINGS      = 7;
    localparam int DEF_COUNTER_WIDTH  = 32;

    localparam int MAX_RINGS   = 16;
    localparam int MAX_SLICES  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int ANG_STEPS   = 13;

    localparam logic [1:0] ACT_HIT  = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    localparam logic [2:0] CFG_DETECTOR_SELECT = 3'd0;
    localparam logic [2:0] CFG_SIGNAL_RING     = 3'd1;
    localparam logic [2:0] CFG_ENERGY_THRESH   = 3'd2;
    localparam logic [2:0] CFG_TARGET_CUT_EN   = 3'd3;
    localparam logic [2:0] CFG_TARGET_CUT_Z    = 3'd4;

    localparam logic [1:0] CLS_CLOSED     = 2'd0;
    localparam logic [1:0] CLS_TRANSITION = 2'd1;
    localparam logic [1:0] CLS_OPEN       = 2'd2;

    typedef struct packed {
        logic [7:0]         detector_select;
        logic [2:0]         signal_ring;
        logic [23:0]        energy_threshold_kev;
        logic               target_cut_enable;
        logic signed [23:0] target_cut_z;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           action;
        logic                 accepted;
        logic                 species;
        logic [1:0]           sector_class;
        logic                 sig;
        logic                 slice_ok;
        logic [3:0]           slice_idx;
        logic [MAX_RINGS-1:0] ring_mask;
        logic signed [23:0]   vertex_z;
        logic [47:0]          vr2;
        logic [8:0]           read_index;
    } job_t;

    typedef struct {
        int          z_lo;
        int          z_hi;
        logic [47:0] r2_lo;
        logic [47:0] r2_hi;
    } box_t;

    function automatic box_t mk_box(input int zb, input int ze, input int rl, input int rh);
        box_t b;
        longint l;
        longint h;
        l = longint'(rl) * 8;
        h = longint'(rh) * 8;
        b.z_lo  = zb * 8;
        b.z_hi  = ze * 8;
        b.r2_lo = 48'(l * l);
        b.r2_hi = 48'(h * h);
        return b;
    endfunction

    function automatic box_t box_at(input logic [5:0] c);
        box_t b;
        b = mk_box(0, 0, 0, 0);
        unique case (c)
            6'd0:  b = mk_box(-6005, -3440, 0, 40);
            6'd1:  b = mk_box(-3439, -2972, 100, 200);
            6'd2:  b = mk_box(-2971, -1310, 100, 188);
            6'd3:  b = mk_box(-1309, -1000, 70, 335);
            6'd4:  b = mk_box(-999, -400, 140, 195);
            6'd5:  b = mk_box(-399, 319, 140, 190);
            6'd6:  b = mk_box(320, 905, 10, 31);
            6'd7:  b = mk_box(745, 905, 20, 152);
            6'd8:  b = mk_box(931, 3094, 20, 65);
            6'd9:  b = mk_box(3220, 3380, 26, 250);
            6'd10: b = mk_box(4177, 4695, 325, 420);
            6'd11: b = mk_box(4595, 4905, 310, 350);
            6'd12: b = mk_box(4696, 4824, 20, 155);
            6'd13: b = mk_box(4929, 5941, 32, 57);
            6'd14: b = mk_box(5946, 6978, 32, 57);
            6'd15: b = mk_box(6495, 9005, 350, 900);
            6'd16: b = mk_box(6982, 7965, 32, 57);
            6'd17: b = mk_box(7549, 7777, 57, 300);
            6'd18: b = mk_box(7975, 9768, 45, 90);
            6'd19: b = mk_box(9550, 9713, 55, 102);
            6'd20: b = mk_box(9551, 9713, 95, 639);
            6'd21: b = mk_box(9639, 9749, 475, 950);
            6'd22: b = mk_box(10922, 11085, 116, 639);
            6'd23: b = mk_box(10922, 11085, 80, 126);
            6'd24: b = mk_box(11810, 11971, 540, 760);
            6'd25: b = mk_box(11995, 12185, 700, 1300);
            6'd26: b = mk_box(12238, 12649, 685, 788);
            6'd27: b = mk_box(12730, 13160, 720, 1275);
            6'd28: b = mk_box(13161, 18826, 1240, 1397);
            6'd29: b = mk_box(18506, 18834, 516, 1074);
            6'd30: b = mk_box(18849, 18923, 1006, 1402);
            6'd31: b = mk_box(18927, 19288, 1010, 1315);
            6'd32: b = mk_box(19006, 20505, 800, 1009);
            6'd33: b = mk_box(19006, 22505, 640, 800);
            6'd34: b = mk_box(19036, 19332, 400, 640);
            6'd35: b = mk_box(19334, 25477, 500, 696);
            6'd36: b = mk_box(21810, 21990, 1040, 1190);
            6'd37: b = mk_box(22100, 22300, 915, 1105);
            6'd38: b = mk_box(22425, 22605, 810, 985);
            6'd39: b = mk_box(22700, 22880, 765, 880);
            6'd40: b = mk_box(22975, 23155, 720, 830);
            6'd41: b = mk_box(23245, 23425, 705, 785);
            default: b = mk_box(0, 0, 0, 0);
        endcase
        return b;
    endfunction

    function automatic int ring_lo(input logic [3:0] k);
        int v;
        unique case (k)
            4'd0: v = 660;
            4'd1: v = 660;
            4'd2: v = 690;
            4'd3: v = 750;
            4'd4: v = 810;
            4'd5: v = 930;
            4'd6: v = 1070;
            default: v = 0;
        endcase
        return v * 8;
    endfunction

    function automatic int ring_hi(input logic [3:0] k);
        int v;
        unique case (k)
            4'd0: v = 1170;
            4'd1: v = 690;
            4'd2: v = 750;
            4'd3: v = 810;
            4'd4: v = 930;
            4'd5: v = 1070;
            4'd6: v = 1170;
            default: v = 0;
        endcase
        return v * 8;
    endfunction

    function automatic int slice_edge(input logic [4:0] s);
        int v;
        unique case (s)
            5'd0: v = -100000;
            5'd1: v = -3700;
            5'd2: v = 2000;
            5'd3: v = 8500;
            5'd4: v = 14500;
            5'd5: v = 22200;
            5'd6: v = 35000;
            default: v = 1000000;
        endcase
        return v * 8;
    endfunction

    function automatic logic [16:0] sin_at(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd0;
            4'd1:  v = 17'd7338;
            4'd2:  v = 17'd14583;
            4'd3:  v = 17'd21645;
            4'd4:  v = 17'd28435;
            4'd5:  v = 17'd34867;
            4'd6:  v = 17'd40861;
            4'd7:  v = 17'd46341;
            4'd8:  v = 17'd51238;
            4'd9:  v = 17'd55491;
            4'd10: v = 17'd59046;
            4'd11: v = 17'd61858;
            4'd12: v = 17'd63893;
            4'd13: v = 17'd65124;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] class_of_unit(input logic [2:0] u);
        logic [1:0] c;
        unique case (u)
            3'd0, 3'd7: c = CLS_CLOSED;
            3'd3, 3'd4: c = CLS_OPEN;
            default:    c = CLS_TRANSITION;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/horc_if.sv */
`timescale 1ns / 1ps
interface horc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         detector_id;
    logic [23:0]        energy_kev;
    logic signed [31:0] particle_code;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic signed [23:0] vertex_z;
    logic signed [23:0] momentum_z;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic [22:0]        hit_radius;
    logic [8:0]         read_index;

    modport source (output valid, action, detector_id, energy_kev, particle_code, vertex_x,
                    vertex_y, vertex_z, momentum_z, hit_x, hit_y, hit_radius, read_index,
                    input ready);
    modport sink (input valid, action, detector_id, energy_kev, particle_code, vertex_x,
                  vertex_y, vertex_z, momentum_z, hit_x, hit_y, hit_radius, read_index,
                  output ready);
endinterface

interface horc_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        species;
    logic [1:0]  sector_class;
    logic        in_signal_ring;
    logic [5:0]  boxes_matched;
    logic        uncovered;
    logic [47:0] counter_value;

    modport source (output valid, accepted, species, sector_class, in_signal_ring,
                    boxes_matched, uncovered, counter_value, input ready);
    modport sink (input valid, accepted, species, sector_class, in_signal_ring,
                  boxes_matched, uncovered, counter_value, output ready);
endinterface

/* rtl/core/horc_front.sv */
`timescale 1ns / 1ps
module horc_front #(
    parameter int NUM_SLICES = horc_pkg::DEF_NUM_SLICES,
    parameter int NUM_RINGS  = horc_pkg::DEF_NUM_RINGS
) (
    input  logic              clk,
    input  logic              rst_n,
    horc_in_if.sink           hit_in,
    input  horc_pkg::cfg_t    cfg,
    input  logic              hold,
    output logic              push_valid,
    input  logic              push_ready,
    output horc_pkg::job_t    push_job
);
    import horc_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_ANG  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [1:0]           action_reg;
    logic [8:0]           read_index_reg;
    logic                 pass_reg;
    logic                 sp_reg;
    logic [1:0]           q_reg;
    logic [23:0]          px_reg, py_reg;
    logic signed [23:0]   vx_reg, vy_reg, vz_reg;
    logic [MAX_RINGS-1:0] ring_mask_reg;
    logic                 sig_reg;
    logic                 slice_ok_reg;
    logic [3:0]           slice_reg;
    logic [3:0]           j_reg, k_reg;
    logic                 ph_reg;
    logic [40:0]          a_reg, b_reg;
    logic signed [47:0]   sqx_reg, sqy_reg;

    logic                 fire;
    logic                 pass_next;
    logic [1:0]           q_next;
    logic [23:0]          px_next, py_next;
    logic [MAX_RINGS-1:0] ring_mask_next;
    logic                 slice_ok_next;
    logic [3:0]           slice_next;
    logic signed [24:0]   xe, ye;
    logic signed [31:0]   rr;
    logic signed [31:0]   vzi;
    logic [5:0]           unit;

    assign hit_in.ready = (state_reg == F_IDLE) && !hold;
    assign fire = hit_in.valid && hit_in.ready;

    always_comb
    begin
        pass_next = (hit_in.action == ACT_HIT)
            && (hit_in.detector_id == cfg.detector_select)
            && (hit_in.energy_kev > cfg.energy_threshold_kev)
            && (hit_in.particle_code == 32'sd11 || hit_in.particle_code == -32'sd11
                || hit_in.particle_code == 32'sd22)
            && !(cfg.target_cut_enable && (hit_in.vertex_z <= cfg.target_cut_z))
            && (hit_in.momentum_z > 24'sd0);

        xe = {hit_in.hit_x[23], hit_in.hit_x};
        ye = {hit_in.hit_y[23], hit_in.hit_y};
        if (xe > 0 && ye >= 0)
        begin
            q_next = 2'd0; px_next = xe[23:0]; py_next = ye[23:0];
        end
        else if (xe <= 0 && ye > 0)
        begin
            q_next = 2'd1; px_next = ye[23:0]; py_next = 24'(-xe);
        end
        else if (xe < 0 && ye <= 0)
        begin
            q_next = 2'd2; px_next = 24'(-xe); py_next = 24'(-ye);
        end
        else
        begin
            q_next = 2'd3; px_next = 24'(-ye); py_next = xe[23:0];
        end

        rr  = $signed({9'd0, hit_in.hit_radius});
        vzi = 32'(hit_in.vertex_z);
        ring_mask_next = '0;
        for (int k = 0; k < MAX_RINGS; k++)
        begin
            if (k < NUM_RINGS)
                ring_mask_next[k] = (rr > ring_lo(4'(k))) && (rr <= ring_hi(4'(k)));
        end
        slice_ok_next = 1'b0;
        slice_next    = '0;
        for (int s = 0; s < MAX_SLICES; s++)
        begin
            if (s < NUM_SLICES && !slice_ok_next
                && vzi > slice_edge(5'(s)) && vzi <= slice_edge(5'(s + 1)))
            begin
                slice_ok_next = 1'b1;
                slice_next    = 4'(s);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (fire) state_next = pass_next ? F_ANG : F_PUSH;
            F_ANG:   if (ph_reg && k_reg == 4'(ANG_STEPS)) state_next = F_PUSH;
            F_PUSH:  if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= 4'd1;
            ph_reg    <= 1'b0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                k_reg  <= 4'd1;
                ph_reg <= 1'b0;
                j_reg  <= '0;
            end
            else if (state_reg == F_ANG)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                begin
                    if (a_reg >= b_reg) j_reg <= k_reg;
                    k_reg <= k_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            action_reg     <= hit_in.action;
            read_index_reg <= hit_in.read_index;
            pass_reg       <= pass_next;
            sp_reg         <= (hit_in.particle_code == 32'sd22);
            q_reg          <= q_next;
            px_reg         <= px_next;
            py_reg         <= py_next;
            vx_reg         <= hit_in.vertex_x;
            vy_reg         <= hit_in.vertex_y;
            vz_reg         <= hit_in.vertex_z;
            ring_mask_reg  <= ring_mask_next;
            sig_reg        <= (32'(cfg.signal_ring) < NUM_RINGS)
                              && ring_mask_next[4'(cfg.signal_ring)];
            slice_ok_reg   <= slice_ok_next;
            slice_reg      <= slice_next;
        end
        a_reg   <= sin_at(4'(ANG_STEPS + 1) - k_reg) * py_reg;
        b_reg   <= sin_at(k_reg) * px_reg;
        sqx_reg <= vx_reg * vx_reg;
        sqy_reg <= vy_reg * vy_reg;
    end

    assign unit = 6'(q_reg * 4'd14) + 6'(j_reg);

    always_comb
    begin
        push_valid            = (state_reg == F_PUSH);
        push_job.action       = action_reg;
        push_job.accepted     = pass_reg;
        push_job.species      = sp_reg;
        push_job.sector_class = class_of_unit(unit[2:0]);
        push_job.sig          = sig_reg;
        push_job.slice_ok     = slice_ok_reg;
        push_job.slice_idx    = slice_reg;
        push_job.ring_mask    = ring_mask_reg;
        push_job.vertex_z     = vz_reg;
        push_job.vr2          = 48'(sqx_reg) + 48'(sqy_reg);
        push_job.read_index   = read_index_reg;
    end

endmodule

/* rtl/core/horc_queue.sv */
`timescale 1ns / 1ps
module horc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  horc_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output horc_pkg::job_t pop_job
);
    import horc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    job_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)  rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) slot_reg[wr_reg] <= push_job;
    end

endmodule

/* rtl/core/horc_back.sv */
`timescale 1ns / 1ps
module horc_back #(
    parameter int NUM_COMPONENTS = horc_pkg::DEF_NUM_COMPONENTS,
    parameter int NUM_SLICES     = horc_pkg::DEF_NUM_SLICES,
    parameter int NUM_RINGS      = horc_pkg::DEF_NUM_RINGS,
    parameter int COUNTER_WIDTH  = horc_pkg::DEF_COUNTER_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  horc_pkg::job_t pop_job,
    output logic           clearing,
    horc_out_if.source     result_out
);
    import horc_pkg::*;

    localparam int N_COMP    = 6 * NUM_COMPONENTS;
    localparam int N_SLICE   = 2 * NUM_SLICES * NUM_RINGS;
    localparam int MEM_DEPTH = N_COMP + N_SLICE + 2;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CW        = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int KW        = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int MW        = $clog2(NUM_COMPONENTS + 1);

    typedef enum logic [8:0] {
        B_CLEAR = 9'b000000001,
        B_IDLE  = 9'b000000010,
        B_BOX   = 9'b000000100,
        B_UNC   = 9'b000001000,
        B_SLICE = 9'b000010000,
        B_RD    = 9'b000100000,
        B_WR    = 9'b001000000,
        B_RDOUT = 9'b010000000,
        B_FIN   = 9'b100000000
    } bstate_t;

    bstate_t state_reg, ret_reg;

    logic [COUNTER_WIDTH-1:0] mem [MEM_DEPTH];
    logic [COUNTER_WIDTH-1:0] rd_data_reg;
    logic [COUNTER_WIDTH-1:0] wdata;
    logic                     mem_we;

    job_t            job_reg;
    logic [AW-1:0]   addr_reg, second_addr_reg;
    logic            second_reg;
    logic [CW-1:0]   c_reg;
    logic [KW-1:0]   k_reg;
    logic [MW-1:0]   matched_reg;
    logic            rd_mem_reg, rd_evt_reg;
    logic [47:0]     event_reg;

    logic            out_valid_reg;
    logic            acc_reg, sp_out_reg, sig_out_reg, unc_reg;
    logic [1:0]      cls_reg;
    logic [5:0]      bm_reg;
    logic [47:0]     value_reg;

    logic            slot_free, fire, load;
    logic            box_match, last_c, last_k, kind_bump;
    box_t            bx;
    logic signed [31:0] vzi;
    int              comp_all, comp_kind, slice_a, unc_a;

    assign slot_free = !out_valid_reg || result_out.ready;
    assign pop_ready = (state_reg == B_IDLE) && slot_free;
    assign fire      = pop_valid && pop_ready;
    assign clearing  = (state_reg == B_CLEAR);
    assign load      = (fire && !(pop_job.action == ACT_HIT && pop_job.accepted)
                        && pop_job.action != ACT_READ) || (state_reg == B_FIN);

    always_comb
    begin
        bx        = box_at(6'(c_reg));
        vzi       = 32'(job_reg.vertex_z);
        box_match = (vzi > bx.z_lo) && (vzi <= bx.z_hi)
                    && (job_reg.vr2 > bx.r2_lo) && (job_reg.vr2 <= bx.r2_hi);
        last_c    = (c_reg == CW'(NUM_COMPONENTS - 1));
        last_k    = (k_reg == KW'(NUM_RINGS - 1));
        kind_bump = (job_reg.sector_class == CLS_CLOSED) || (job_reg.sector_class == CLS_OPEN);
        comp_all  = int'(job_reg.species) * 3 * NUM_COMPONENTS + int'(c_reg);
        comp_kind = (int'(job_reg.species) * 3
                     + ((job_reg.sector_class == CLS_CLOSED) ? 1 : 2)) * NUM_COMPONENTS
                    + int'(c_reg);
        slice_a   = N_COMP + (int'(job_reg.species) * NUM_SLICES + int'(job_reg.slice_idx))
                    * NUM_RINGS + int'(k_reg);
        unc_a     = N_COMP + N_SLICE + int'(job_reg.species);
        mem_we    = (state_reg == B_WR) || (state_reg == B_CLEAR);
        if (state_reg == B_CLEAR)
            wdata = '0;
        else if (&rd_data_reg)
            wdata = rd_data_reg;
        else
            wdata = rd_data_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[addr_reg] <= wdata;
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_CLEAR;
            ret_reg         <= B_IDLE;
            addr_reg        <= '0;
            second_addr_reg <= '0;
            second_reg      <= 1'b0;
            c_reg           <= '0;
            k_reg           <= '0;
            matched_reg     <= '0;
            event_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                B_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(MEM_DEPTH - 1))
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (fire)
                    begin
                        c_reg       <= '0;
                        k_reg       <= '0;
                        matched_reg <= '0;
                        if (pop_job.action == ACT_HIT && pop_job.accepted)
                            state_reg <= pop_job.sig ? B_BOX : B_SLICE;
                        else if (pop_job.action == ACT_READ)
                        begin
                            addr_reg  <= AW'(pop_job.read_index);
                            state_reg <= B_RDOUT;
                        end
                        else if (pop_job.action == ACT_TICK && !(&event_reg))
                            event_reg <= event_reg + 1'b1;
                    end
                end
                B_BOX:
                begin
                    c_reg <= c_reg + 1'b1;
                    if (box_match)
                    begin
                        matched_reg     <= matched_reg + 1'b1;
                        addr_reg        <= AW'(comp_all);
                        second_addr_reg <= AW'(comp_kind);
                        second_reg      <= kind_bump;
                        ret_reg         <= last_c ? B_UNC : B_BOX;
                        state_reg       <= B_RD;
                    end
                    else if (last_c)
                        state_reg <= B_UNC;
                end
                B_UNC:
                begin
                    if (matched_reg == '0)
                    begin
                        addr_reg   <= AW'(unc_a);
                        second_reg <= 1'b0;
                        ret_reg    <= B_SLICE;
                        state_reg  <= B_RD;
                    end
                    else
                        state_reg <= B_SLICE;
                end
                B_SLICE:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (!job_reg.slice_ok)
                        state_reg <= B_FIN;
                    else if (job_reg.ring_mask[4'(k_reg)])
                    begin
                        addr_reg   <= AW'(slice_a);
                        second_reg <= 1'b0;
                        ret_reg    <= last_k ? B_FIN : B_SLICE;
                        state_reg  <= B_RD;
                    end
                    else if (last_k)
                        state_reg <= B_FIN;
                end
                B_RD:
                    state_reg <= B_WR;
                B_WR:
                begin
                    if (second_reg)
                    begin
                        addr_reg   <= second_addr_reg;
                        second_reg <= 1'b0;
                        state_reg  <= B_RD;
                    end
                    else
                        state_reg <= ret_reg;
                end
                B_RDOUT:
                    state_reg <= B_FIN;
                B_FIN:
                    state_reg <= B_IDLE;
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            job_reg    <= pop_job;
            rd_mem_reg <= (32'(pop_job.read_index) < MEM_DEPTH);
            rd_evt_reg <= (32'(pop_job.read_index) == MEM_DEPTH);
        end
        if (load)
        begin
            if (state_reg == B_FIN && job_reg.action == ACT_HIT)
            begin
                acc_reg     <= 1'b1;
                sp_out_reg  <= job_reg.species;
                cls_reg     <= job_reg.sector_class;
                sig_out_reg <= job_reg.sig;
                bm_reg      <= 6'(matched_reg);
                unc_reg     <= job_reg.sig && (matched_reg == '0);
                value_reg   <= '0;
            end
            else
            begin
                acc_reg     <= 1'b0;
                sp_out_reg  <= 1'b0;
                cls_reg     <= CLS_CLOSED;
                sig_out_reg <= 1'b0;
                bm_reg      <= '0;
                unc_reg     <= 1'b0;
                if (state_reg == B_FIN && rd_mem_reg)
                    value_reg <= 48'(rd_data_reg);
                else if (state_reg == B_FIN && rd_evt_reg)
                    value_reg <= event_reg;
                else
                    value_reg <= '0;
            end
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.accepted       = acc_reg;
    assign result_out.species        = sp_out_reg;
    assign result_out.sector_class   = cls_reg;
    assign result_out.in_signal_ring = sig_out_reg;
    assign result_out.boxes_matched  = bm_reg;
    assign result_out.uncovered      = unc_reg;
    assign result_out.counter_value  = value_reg;

    a_matched_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(matched_reg) <= NUM_COMPONENTS)
        else $error("match count past component count");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !pop_ready)
        else $error("queue popped during clearing pass");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WR) |-> $past(state_reg == B_RD))
        else $error("counter write without preceding read");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || result_out.ready))
        else $error("result overwritten before taken");

endmodule

/* rtl/core/hit_origin_region_counter_top.sv */
`timescale 1ns / 1ps
// Hit origin region counter. Each transaction is a hit, a beam tick, a no-op or a counter
// read and gives one result. A selected hit goes through 13 angle steps in the front on one
// multiplier pair, then in the back, if it lies in the signal ring, through a pass over the
// component boxes (NUM_COMPONENTS), and, if its vertex lies in a slice, a pass over the
// rings. Each counter bump is a read, then a write, on the single counter memory port.
// Front and back overlap through a two-entry queue. After reset a clearing pass writes
// zero to all 6*NUM_COMPONENTS + 2*NUM_SLICES*NUM_RINGS + 2 counter memory entries (352
// by default), one entry a cycle; no input is taken meanwhile, configuration writes are.
module hit_origin_region_counter_top #(
    parameter int NUM_COMPONENTS = horc_pkg::DEF_NUM_COMPONENTS,
    parameter int NUM_SLICES     = horc_pkg::DEF_NUM_SLICES,
    parameter int NUM_RINGS      = horc_pkg::DEF_NUM_RINGS,
    parameter int COUNTER_WIDTH  = horc_pkg::DEF_COUNTER_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    horc_in_if.sink     hit_in,
    horc_out_if.source  result_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import horc_pkg::*;

    cfg_t cfg_reg;
    logic push_valid, push_ready, pop_valid, pop_ready, clearing;
    job_t push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detector_select      <= 8'd28;
            cfg_reg.signal_ring          <= 3'd5;
            cfg_reg.energy_threshold_kev <= 24'd1000;
            cfg_reg.target_cut_enable    <= 1'b0;
            cfg_reg.target_cut_z         <= -24'sd27520;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DETECTOR_SELECT: cfg_reg.detector_select      <= cfg_data[7:0];
                CFG_SIGNAL_RING:     cfg_reg.signal_ring          <= cfg_data[2:0];
                CFG_ENERGY_THRESH:   cfg_reg.energy_threshold_kev <= cfg_data;
                CFG_TARGET_CUT_EN:   cfg_reg.target_cut_enable    <= cfg_data[0];
                CFG_TARGET_CUT_Z:    cfg_reg.target_cut_z         <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    horc_front #(
        .NUM_SLICES (NUM_SLICES),
        .NUM_RINGS  (NUM_RINGS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hit_in     (hit_in),
        .cfg        (cfg_reg),
        .hold       (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    horc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    horc_back #(
        .NUM_COMPONENTS (NUM_COMPONENTS),
        .NUM_SLICES     (NUM_SLICES),
        .NUM_RINGS      (NUM_RINGS),
        .COUNTER_WIDTH  (COUNTER_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .clearing   (clearing),
        .result_out (result_out)
    );

endmodule
